// ----- design/bpa_pkg.sv -----
package bpa_pkg;

   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_ADD   = 2'd2;
   localparam logic [1:0] ACT_UNDEF = 2'd3;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_RANGE   = 2'd2;

   typedef struct packed {
      logic clr_step;
      logic load_req;
      logic set_k;
      logic free_clear;
      logic k_inc;
      logic pop;
      logic take_top;
      logic split_push;
      logic head_read;
      logic scan_init;
      logic scan_read;
      logic scan_dec;
      logic shift_init;
      logic shift_read;
      logic shift_write;
      logic merge;
      logic push_final;
      logic res_fail;
      logic res_range;
      logic res_alloc;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic       invalid;
      logic [1:0] action;
      logic       k_top;
      logic       fill_nz;
      logic       h_gt;
      logic       stop_merge;
      logic       head_match;
      logic       i_zero;
      logic       match;
      logic       shift_more;
      logic       out_free;
   } status_type;

endpackage

// ----- design/buddy_page_allocator.sv -----
// Buddy page allocator: one request beat (allocate, free with merging, or add) gives one
// response beat. After reset the page-mark memory is cleared entry by entry before the
// first request is taken. An allocate searches the orders upward from the requested one,
// pops the first non-empty stack and splits the block down; a free checks each merge step,
// reads the buddy's head mark, scans its stack for the buddy and moves the later entries
// down to take it out; every request passes decode and result. All of it is bound by the
// single registered read port of the stack memory.
module buddy_page_allocator #(
   parameter int NUM_PAGES  = 1024,
   parameter int TOP_ORDERS = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // block_order[3:0], page_index[13:4], zero pad
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // result_page[9:0], result_order[13:10], zero pad
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   bpa_pkg::cmd_type    cmd;
   bpa_pkg::status_type st;
   logic [9:0] page;
   logic [3:0] order;

   bpa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .st       (st),
      .cmd      (cmd)
   );

   bpa_datapath #(.NUM_PAGES(NUM_PAGES), .TOP_ORDERS(TOP_ORDERS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .in_action  (req_tuser),
      .in_order   (req_tdata[3:0]),
      .in_page    (req_tdata[13:4]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (rsp_tuser),
      .out_page   (page),
      .out_order  (order)
   );

   assign rsp_tdata = {2'b00, order, page};

endmodule

// ----- design/bpa_ram.sv -----
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/bpa_ctrl.sv -----
module bpa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bpa_pkg::status_type st,
   output bpa_pkg::cmd_type    cmd
);

   typedef enum logic [13:0] {
      S_CLEAR   = 14'b00000000000001,
      S_IDLE    = 14'b00000000000010,
      S_DECODE  = 14'b00000000000100,
      S_SEARCH  = 14'b00000000001000,
      S_POPWAIT = 14'b00000000010000,
      S_SPLIT   = 14'b00000000100000,
      S_MCHK    = 14'b00000001000000,
      S_MHEAD   = 14'b00000010000000,
      S_SCAN    = 14'b00000100000000,
      S_SCANCHK = 14'b00001000000000,
      S_SHIFT   = 14'b00010000000000,
      S_SHWR    = 14'b00100000000000,
      S_FPUSH   = 14'b01000000000000,
      S_RESULT  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (st.invalid) begin
               cmd.res_range = 1'b1;
               state_in      = S_RESULT;
            end else begin
               cmd.set_k = 1'b1;
               case (st.action)
                  bpa_pkg::ACT_ALLOC: state_in = S_SEARCH;
                  bpa_pkg::ACT_FREE: begin
                     cmd.free_clear = 1'b1;
                     state_in       = S_MCHK;
                  end
                  default: state_in = S_FPUSH;
               endcase
            end
         end
         S_SEARCH: begin
            if (st.k_top) begin
               cmd.res_fail = 1'b1;
               state_in     = S_RESULT;
            end else if (st.fill_nz) begin
               cmd.pop  = 1'b1;
               state_in = S_POPWAIT;
            end else begin
               cmd.k_inc = 1'b1;
            end
         end
         S_POPWAIT: begin
            cmd.take_top = 1'b1;
            state_in     = S_SPLIT;
         end
         S_SPLIT: begin
            if (st.h_gt) begin
               cmd.split_push = 1'b1;
            end else begin
               cmd.res_alloc = 1'b1;
               state_in      = S_RESULT;
            end
         end
         S_MCHK: begin
            if (st.stop_merge) begin
               state_in = S_FPUSH;
            end else begin
               cmd.head_read = 1'b1;
               state_in      = S_MHEAD;
            end
         end
         S_MHEAD: begin
            if (st.head_match) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else begin
               state_in = S_FPUSH;
            end
         end
         S_SCAN: begin
            if (st.i_zero) begin
               state_in = S_FPUSH;
            end else begin
               cmd.scan_read = 1'b1;
               state_in      = S_SCANCHK;
            end
         end
         S_SCANCHK: begin
            if (st.match) begin
               cmd.shift_init = 1'b1;
               state_in       = S_SHIFT;
            end else begin
               cmd.scan_dec = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_SHIFT: begin
            if (st.shift_more) begin
               cmd.shift_read = 1'b1;
               state_in       = S_SHWR;
            end else begin
               cmd.merge = 1'b1;
               state_in  = S_MCHK;
            end
         end
         S_SHWR: begin
            cmd.shift_write = 1'b1;
            state_in        = S_SHIFT;
         end
         S_FPUSH: begin
            cmd.push_final = 1'b1;
            state_in       = S_RESULT;
         end
         S_RESULT: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

endmodule

// ----- design/bpa_datapath.sv -----
module bpa_datapath #(
   parameter int NUM_PAGES  = 1024,
   parameter int TOP_ORDERS = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  bpa_pkg::cmd_type    cmd,
   output bpa_pkg::status_type st,
   input  logic [1:0]          in_action,
   input  logic [3:0]          in_order,
   input  logic [9:0]          in_page,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [1:0]          out_status,
   output logic [9:0]          out_page,
   output logic [3:0]          out_order
);

   localparam int PW  = $clog2(NUM_PAGES);
   localparam int SAW = $clog2(2 * NUM_PAGES);
   localparam int FW  = $clog2(NUM_PAGES + 1);
   localparam int KW  = $clog2(TOP_ORDERS + 1);
   localparam int OW  = $clog2(TOP_ORDERS);
   localparam int HW  = $clog2(TOP_ORDERS + 1);
   localparam int XW  = (PW > TOP_ORDERS) ? PW + 1 : TOP_ORDERS + 1;
   localparam logic [SAW:0]  D2  = (SAW + 1)'(2 * NUM_PAGES);
   localparam logic [FW-1:0] NPF = FW'(NUM_PAGES);
   localparam logic [XW-1:0] NPX = XW'(NUM_PAGES);

   logic [FW-1:0] fill_ff [TOP_ORDERS];
   logic [PW-1:0] clr_ff;
   logic [1:0]    act_ff;
   logic [3:0]    ord_ff;
   logic [PW-1:0] p_ff, top_ff;
   logic [KW-1:0] k_ff, h_ff;
   logic [FW-1:0] i_ff, j_ff;
   logic [1:0]    res_st_ff;
   logic [PW-1:0] res_pg_ff;
   logic [KW-1:0] res_ord_ff;
   logic          out_valid_ff;
   logic [1:0]    out_st_ff;
   logic [9:0]    out_pg_ff;
   logic [3:0]    out_ord_ff;

   logic [KW-1:0]  hm1;
   logic [KW-1:0]  sel_ord;
   logic [SAW-1:0] base_sel, base_k;
   logic [FW-1:0]  cap_sel, fill_sel, fill_k;
   logic [XW-1:0]  push_pg, buddy;
   logic           push_en, push_ok;

   logic            s_we;
   logic [SAW-1:0]  s_waddr, s_raddr;
   logic [PW-1:0]   s_wdata, s_rdata;
   logic            h_we;
   logic [PW-1:0]   h_waddr, h_raddr;
   logic [HW-1:0]   h_wdata, h_rdata;

   assign hm1      = h_ff - KW'(1);
   assign sel_ord  = cmd.split_push ? hm1 : k_ff;
   assign base_sel = SAW'(D2 - (((D2 >> 1) >> sel_ord) << 1));
   assign base_k   = SAW'(D2 - (((D2 >> 1) >> k_ff) << 1));
   assign cap_sel  = NPF >> sel_ord;
   assign fill_sel = fill_ff[sel_ord[OW-1:0]];
   assign fill_k   = fill_ff[k_ff[OW-1:0]];
   assign buddy    = XW'(p_ff) ^ (XW'(1) << k_ff);

   // split pushes the upper half of the block at the next lower order
   assign push_pg  = cmd.split_push ? (XW'(top_ff) + (XW'(1) << hm1)) : XW'(p_ff);
   assign push_en  = cmd.split_push | cmd.push_final;
   assign push_ok  = push_en && (push_pg < NPX) && (fill_sel < cap_sel);

   always_comb begin
      s_we    = 1'b0;
      s_waddr = base_sel + SAW'(fill_sel);
      s_wdata = push_pg[PW-1:0];
      s_raddr = base_k + SAW'(j_ff) + SAW'(1);
      if (push_ok) begin
         s_we = 1'b1;
      end else if (cmd.shift_write) begin
         s_we    = 1'b1;
         s_waddr = base_k + SAW'(j_ff);
         s_wdata = s_rdata;
      end
      if (cmd.pop) begin
         s_raddr = base_k + SAW'(fill_k) - SAW'(1);
      end else if (cmd.scan_read) begin
         s_raddr = base_k + SAW'(i_ff) - SAW'(1);
      end
   end

   always_comb begin
      h_we    = 1'b0;
      h_waddr = clr_ff;
      h_wdata = '0;
      h_raddr = buddy[PW-1:0];
      if (cmd.clr_step) begin
         h_we = 1'b1;
      end else if (cmd.take_top) begin
         h_we    = (XW'(s_rdata) < NPX);
         h_waddr = s_rdata;
      end else if (cmd.free_clear) begin
         h_we    = 1'b1;
         h_waddr = p_ff;
      end else if (cmd.merge) begin
         h_we    = 1'b1;
         h_waddr = buddy[PW-1:0];
      end else if (push_ok) begin
         h_we    = 1'b1;
         h_waddr = push_pg[PW-1:0];
         h_wdata = HW'(sel_ord) + HW'(1);
      end
   end

   bpa_ram #(.WIDTH(PW), .DEPTH(2 * NUM_PAGES)) u_stack_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   bpa_ram #(.WIDTH(HW), .DEPTH(NUM_PAGES)) u_head_ram (
      .clock (clock),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (h_wdata),
      .raddr (h_raddr),
      .rdata (h_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int n = 0; n < TOP_ORDERS; n++) begin
            fill_ff[n] <= '0;
         end
      end else begin
         if (cmd.clr_step) clr_ff <= clr_ff + PW'(1);
         if (cmd.pop) begin
            fill_ff[k_ff[OW-1:0]] <= fill_k - FW'(1);
         end else if (cmd.merge) begin
            fill_ff[k_ff[OW-1:0]] <= fill_k - FW'(1);
         end else if (push_ok) begin
            fill_ff[sel_ord[OW-1:0]] <= fill_sel + FW'(1);
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff <= in_action;
         ord_ff <= in_order;
         p_ff   <= PW'(in_page);
      end
      if (cmd.set_k) k_ff <= KW'(ord_ff);
      if (cmd.k_inc) k_ff <= k_ff + KW'(1);
      if (cmd.take_top) begin
         top_ff <= s_rdata;
         h_ff   <= k_ff;
      end
      if (cmd.split_push) h_ff <= hm1;
      if (cmd.scan_init) i_ff <= fill_k;
      if (cmd.scan_dec) i_ff <= i_ff - FW'(1);
      if (cmd.shift_init) j_ff <= i_ff - FW'(1);
      if (cmd.shift_write) j_ff <= j_ff + FW'(1);
      if (cmd.merge) begin
         p_ff <= p_ff & buddy[PW-1:0];
         k_ff <= k_ff + KW'(1);
      end
      if (cmd.res_fail || cmd.res_range) begin
         res_st_ff  <= cmd.res_fail ? bpa_pkg::ST_NOSPACE : bpa_pkg::ST_RANGE;
         res_pg_ff  <= '0;
         res_ord_ff <= '0;
      end else if (cmd.res_alloc) begin
         res_st_ff  <= bpa_pkg::ST_DONE;
         res_pg_ff  <= top_ff;
         res_ord_ff <= KW'(ord_ff);
      end else if (cmd.push_final) begin
         res_st_ff  <= bpa_pkg::ST_DONE;
         res_pg_ff  <= p_ff;
         res_ord_ff <= k_ff;
      end
      if (cmd.out_load) begin
         out_st_ff  <= res_st_ff;
         out_pg_ff  <= 10'(res_pg_ff);
         out_ord_ff <= 4'(res_ord_ff);
      end
   end

   always_comb begin
      st            = '0;
      st.clr_last   = (clr_ff == PW'(NUM_PAGES - 1));
      st.invalid    = (act_ff == bpa_pkg::ACT_UNDEF) || (int'(ord_ff) >= TOP_ORDERS);
      st.action     = act_ff;
      st.k_top      = (k_ff == KW'(TOP_ORDERS));
      st.fill_nz    = (fill_k != '0);
      st.h_gt       = (int'(h_ff) > int'(ord_ff));
      st.stop_merge = (int'(k_ff) + 1 >= TOP_ORDERS) || (buddy >= NPX);
      st.head_match = (h_rdata == HW'(int'(k_ff) + 1));
      st.i_zero     = (i_ff == '0);
      st.match      = (s_rdata == buddy[PW-1:0]);
      st.shift_more = ((FW + 1)'(j_ff) + (FW + 1)'(1)) < (FW + 1)'(fill_k);
      st.out_free   = !out_valid_ff || out_ready;
   end

   assign out_valid  = out_valid_ff;
   assign out_status = out_st_ff;
   assign out_page   = out_pg_ff;
   assign out_order  = out_ord_ff;

endmodule

// ----- test/buddy_page_allocator_test.sv -----
`timescale 1ns / 1ps

module buddy_page_allocator_test;

   localparam int PAGES  = 1024;
   localparam int ORDERS = 11;

   typedef struct {
      logic [1:0] act;
      logic [3:0] ord;
      logic [9:0] pg;
   } page_req_type;

   typedef struct {
      logic [1:0] status;
      logic [9:0] page;
      logic [3:0] order;
   } page_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // block_order[3:0], page_index[13:4], zero pad
   logic [1:0]  req_tuser = '0;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // result_page[9:0], result_order[13:10], zero pad
   logic [1:0]  rsp_tuser;        // status[1:0]

   buddy_page_allocator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // allocator shadow state
   logic [9:0] free_heads[ORDERS][$];
   logic [3:0] head_mark[PAGES];

   page_req_type pending_reqs[$];
   page_rsp_type req_outcomes[$];   // outcome of each pending request, in step
   page_rsp_type awaited_rsps[$];
   int errors = 0;
   int n_alloc = 0, n_free = 0, n_add = 0, n_reject = 0, n_nospace = 0;

   function automatic void push_head(int pg, int k);
      if (pg >= PAGES || free_heads[k].size() >= (PAGES >> k))
         return;
      free_heads[k].push_back(pg[9:0]);
      head_mark[pg] = k + 1;
   endfunction

   function automatic bit take_head(int pg, int k);
      for (int i = free_heads[k].size() - 1; i >= 0; i--) begin
         if (free_heads[k][i] == pg) begin
            free_heads[k].delete(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic page_rsp_type allocate_pages(page_req_type r);
      page_rsp_type res;
      int p, k, b, top;
      res = '{bpa_pkg::ST_DONE, 10'd0, 4'd0};
      if (r.act == bpa_pkg::ACT_UNDEF || r.ord >= ORDERS) begin
         res.status = bpa_pkg::ST_RANGE;
         n_reject++;
      end else if (r.act == bpa_pkg::ACT_ALLOC) begin
         res.status = bpa_pkg::ST_NOSPACE;
         n_alloc++;
         for (k = r.ord; k < ORDERS; k++) begin
            if (free_heads[k].size() != 0) begin
               top = free_heads[k].pop_back();
               head_mark[top] = 0;
               for (int h = k - 1; h >= int'(r.ord); h--)
                  push_head(top + (1 << h), h);
               res = '{bpa_pkg::ST_DONE, top[9:0], r.ord};
               break;
            end
         end
         if (res.status == bpa_pkg::ST_NOSPACE)
            n_nospace++;
      end else if (r.act == bpa_pkg::ACT_FREE) begin
         n_free++;
         p = r.pg;
         k = r.ord;
         head_mark[p] = 0;
         while (k + 1 < ORDERS) begin
            b = p ^ (1 << k);
            if (b >= PAGES || head_mark[b] != k + 1 || !take_head(b, k))
               break;
            head_mark[b] = 0;
            p = p & b;
            k++;
         end
         push_head(p, k);
         res.page = p[9:0];
         res.order = k[3:0];
      end else begin
         n_add++;
         push_head(r.pg, r.ord);
         res.page = r.pg;
         res.order = r.ord;
      end
      return res;
   endfunction

   // stimulus is shaped by the predicted outcomes, so prediction runs as items are queued
   function automatic page_rsp_type queue_req(logic [1:0] act, int ord, int pg);
      page_req_type r;
      page_rsp_type res;
      r = '{act, ord[3:0], pg[9:0]};
      res = allocate_pages(r);
      pending_reqs.push_back(r);
      req_outcomes.push_back(res);
      return res;
   endfunction

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_reqs.pop_front();
            awaited_rsps.push_back(req_outcomes.pop_front());
            if (pending_reqs.size() > 150 && $urandom_range(0, 3) == 0)
               req_gap = $urandom_range(1, 13);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= {2'b00, pending_reqs[0].pg, pending_reqs[0].ord};
               req_tuser <= pending_reqs[0].act;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int rsp_stall = 0;
   always @(posedge clock) begin
      page_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_rsps.size() == 0) begin
               $error("response beat with nothing outstanding");
               errors++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[9:0] !== want.page) begin
                  $error("result_page: expected %0d, got %0d", want.page, rsp_tdata[9:0]);
                  errors++;
               end
               if (rsp_tdata[13:10] !== want.order) begin
                  $error("result_order: expected %0d, got %0d", want.order,
                         rsp_tdata[13:10]);
                  errors++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if (pending_reqs.size() > 150 && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(0, 12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      page_rsp_type res;
      page_rsp_type live_blocks[$];
      int idx, pick;

      for (int i = 0; i < PAGES; i++)
         head_mark[i] = 0;

      // directed opening
      res = queue_req(bpa_pkg::ACT_ALLOC, 0, 0);     // empty pool
      res = queue_req(bpa_pkg::ACT_ALLOC, 11, 0);    // order out of range
      res = queue_req(bpa_pkg::ACT_FREE, 15, 1023);
      res = queue_req(bpa_pkg::ACT_UNDEF, 3, 5);     // undefined action
      res = queue_req(bpa_pkg::ACT_ADD, 10, 0);
      res = queue_req(bpa_pkg::ACT_ADD, 10, 0);      // full top stack, dropped
      res = queue_req(bpa_pkg::ACT_ALLOC, 0, 1023);  // full split chain
      res = queue_req(bpa_pkg::ACT_FREE, 0, 0);      // merges all the way to the top
      res = queue_req(bpa_pkg::ACT_ALLOC, 10, 0);
      res = queue_req(bpa_pkg::ACT_ALLOC, 10, 0);    // nothing left
      res = queue_req(bpa_pkg::ACT_ADD, 0, 1023);
      res = queue_req(bpa_pkg::ACT_ADD, 0, 1023);    // duplicate add, stale entry
      res = queue_req(bpa_pkg::ACT_ALLOC, 0, 0);
      res = queue_req(bpa_pkg::ACT_ALLOC, 0, 0);     // hands out the stale copy
      res = queue_req(bpa_pkg::ACT_ADD, 3, 12);      // unaligned block
      res = queue_req(bpa_pkg::ACT_FREE, 3, 4);      // buddy via xor/and rules
      res = queue_req(bpa_pkg::ACT_ADD, 9, 512);
      res = queue_req(bpa_pkg::ACT_FREE, 9, 0);      // merge into top order
      res = queue_req(bpa_pkg::ACT_FREE, 10, 0);     // top order, no further merge
      res = queue_req(bpa_pkg::ACT_ALLOC, 5, 682);

      for (int n = 0; n < 1330; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            res = queue_req(bpa_pkg::ACT_ALLOC, (pick < 3) ? $urandom_range(0, 10)
                            : $urandom_range(0, 4), $urandom_range(0, 1023));
            if (res.status == bpa_pkg::ST_DONE)
               live_blocks.push_back(res);
         end else if (pick < 80) begin
            if (live_blocks.size() != 0) begin
               idx = $urandom_range(0, live_blocks.size() - 1);
               res = queue_req(bpa_pkg::ACT_FREE, live_blocks[idx].order,
                               live_blocks[idx].page);
               live_blocks.delete(idx);
            end else begin
               res = queue_req(bpa_pkg::ACT_ADD, 10, 0);
            end
         end else if (pick < 88) begin
            res = queue_req(bpa_pkg::ACT_ADD, $urandom_range(0, 10),
                            $urandom_range(0, 1023));
         end else if (pick < 93) begin
            res = queue_req(bpa_pkg::ACT_FREE, $urandom_range(0, 10),
                            $urandom_range(0, 1023));
         end else if (pick < 97) begin
            res = queue_req(2'($urandom_range(0, 2)), $urandom_range(11, 15),
                            $urandom_range(0, 1023));
         end else begin
            res = queue_req(bpa_pkg::ACT_UNDEF, $urandom_range(0, 15),
                            $urandom_range(0, 1023));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (pending_reqs.size() == 0 && awaited_rsps.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d allocates (%0d out of space), %0d frees, %0d adds,",
               n_alloc, n_nospace, n_free, n_add);
      $display("and %0d out-of-range or undefined requests", n_reject);
      if (errors == 0 && awaited_rsps.size() == 0) begin
         $display("buddy_page_allocator verification clean");
      end else begin
         $display("buddy_page_allocator verification failed");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("buddy_page_allocator verification failed");
      $finish;
   end

endmodule
